// ----- hdl/afrg_pkg.sv -----
`default_nettype none

package afrg_pkg;

  localparam int unsigned RingDeg = 31;
  localparam int unsigned RingSep = 3;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned WordW   = 32;
  localparam int unsigned ValueW  = 31;
  localparam int unsigned LcgMult = 16807;
  localparam logic [ValueW-1:0] LcgMod = 31'h7FFF_FFFF;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [WordW-1:0] word_t;

  typedef enum logic [2:0] {
    StIdle,
    StSeedMul,
    StSeedRed,
    StStepRd,
    StStepWr
  } state_e;

  // Advance a ring index, wrapping from the last word to word 0.
  function automatic idx_t next_idx(input idx_t idx);
    idx_t res;
    if (idx == idx_t'(RingDeg - 1)) begin
      res = '0;
    end else begin
      res = idx + idx_t'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/afrg_seed_mul.sv -----
`default_nettype none

module afrg_seed_mul
  import afrg_pkg::*;
(
  input  wire logic  clk_i,
  input  wire word_t prev_i,
  output word_t      word_o
);

  localparam int unsigned ProdW = WordW + 16;

  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] prod_d;
  logic signed [16:0]      hi;
  logic signed [32:0]      sum;
  logic signed [32:0]      res;

  assign prod_d = ProdW'(signed'(16'(LcgMult))) * ProdW'(signed'(prev_i));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // 2^31 is congruent to 1 mod 2^31-1: fold the high part onto the low part.
  always_comb begin
    hi  = prod_q[ProdW-1:ValueW];
    sum = 33'(hi) + signed'({2'b00, prod_q[ValueW-1:0]});
    if (sum < 0) begin
      res = sum + signed'({2'b00, LcgMod});
    end else if (sum >= signed'({2'b00, LcgMod})) begin
      res = sum - signed'({2'b00, LcgMod});
    end else begin
      res = sum;
    end
    word_o = {1'b0, res[ValueW-1:0]};
  end

endmodule

`default_nettype wire

// ----- hdl/additive_feedback_random_generator.sv -----
// Additive-feedback random generator, 31-word ring, taps 31 and 3.
// Input stream: each transfer requests one value. tdata bit 0 is restart,
// tlast is end_of_run. Output stream: tdata[30:0] is the value, tlast
// copies end_of_run of the request.
// Configuration: cfg_we_i writes cfg_wdata_i to the seed register; it is
// used at the next reseed only. Write it while the block is idle.
// An ordinary request, after its accepting edge, passes through StStepRd,
// which reads both ring words from the register file, then StStepWr, which
// adds them, writes back and loads the output register. A request with
// restart set, or the first after reset, reseeds first: word 0 is written
// at the accepting edge, then words 1 to 30 are filled one by one, each
// through StSeedMul and StSeedRed of the shared multiply and fold unit,
// then WARMUP_STEPS discarded steps run (310 at the default), then the
// ordinary step. The input is ready only while the sequencer is idle, so a
// new request is taken only once the last one is done. If the receiver
// stalls, the finished result waits in the output register and the next
// request holds before its write-back until the output is taken.
// Reset returns the indices to 3 and 0, clears the seed to 1 and forces a
// reseed on the first request; the ring contents are not cleared.
`default_nettype none

module additive_feedback_random_generator
  import afrg_pkg::*;
#(
  parameter int unsigned WARMUP_STEPS = 310
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,  // [0] restart, [7:1] zero
  input  wire logic        s_axis_tlast_i,  // end_of_run
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // [30:0] value, [31] zero
  output logic             m_axis_tlast_o   // last_of_run
);

  localparam int unsigned CntW = (WARMUP_STEPS > 0) ? $clog2(WARMUP_STEPS + 1) : 1;

  state_e state_q, state_d;
  idx_t   front_q, front_d;
  idx_t   rear_q, rear_d;
  idx_t   seed_idx_q, seed_idx_d;
  logic   seeded_q, seeded_d;
  word_t  seed_q;
  logic [CntW-1:0] warm_q, warm_d;
  logic   out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  logic   out_last_q, out_last_d;
  logic   last_q, last_d;
  word_t  prev_q, prev_d;

  word_t  ring_mem [RingDeg];
  word_t  rd_front_q, rd_rear_q;
  logic   mem_we;
  idx_t   mem_waddr;
  word_t  mem_wdata;

  word_t  fold_word;
  word_t  step_sum;
  logic   in_xfer;
  logic   out_xfer;

  afrg_seed_mul u_seed_mul (
    .clk_i  (clk_i),
    .prev_i (prev_q),
    .word_o (fold_word)
  );

  assign s_axis_tready_o = (state_q == StIdle);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_xfer        = out_valid_q && m_axis_tready_i;
  assign step_sum        = rd_front_q + rd_rear_q;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_value_q};
  assign m_axis_tlast_o  = out_last_q;

  always_comb begin
    state_d     = state_q;
    front_d     = front_q;
    rear_d      = rear_q;
    seed_idx_d  = seed_idx_q;
    seeded_d    = seeded_q;
    warm_d      = warm_q;
    out_valid_d = out_valid_q && !out_xfer;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    last_d      = last_q;
    prev_d      = prev_q;
    mem_we      = 1'b0;
    mem_waddr   = seed_idx_q;
    mem_wdata   = fold_word;

    case (state_q)
      StIdle: begin
        if (in_xfer) begin
          last_d = s_axis_tlast_i;
          if (s_axis_tdata_i[0] || !seeded_q) begin
            // A zero seed is taken as one.
            prev_d     = (seed_q == '0) ? word_t'(1) : seed_q;
            mem_we     = 1'b1;
            mem_waddr  = '0;
            mem_wdata  = prev_d;
            seed_idx_d = idx_t'(1);
            state_d    = StSeedMul;
          end else begin
            state_d = StStepRd;
          end
        end
      end
      StSeedMul: begin
        state_d = StSeedRed;
      end
      StSeedRed: begin
        mem_we = 1'b1;
        prev_d = fold_word;
        if (seed_idx_q == idx_t'(RingDeg - 1)) begin
          front_d  = idx_t'(RingSep);
          rear_d   = '0;
          warm_d   = CntW'(WARMUP_STEPS);
          seeded_d = 1'b1;
          state_d  = StStepRd;
        end else begin
          seed_idx_d = seed_idx_q + idx_t'(1);
          state_d    = StSeedMul;
        end
      end
      StStepRd: begin
        state_d = StStepWr;
      end
      StStepWr: begin
        mem_waddr = front_q;
        mem_wdata = step_sum;
        if (warm_q != '0) begin
          mem_we  = 1'b1;
          front_d = next_idx(front_q);
          rear_d  = next_idx(rear_q);
          warm_d  = warm_q - CntW'(1);
          state_d = StStepRd;
        end else if (!out_valid_q || m_axis_tready_i) begin
          mem_we      = 1'b1;
          front_d     = next_idx(front_q);
          rear_d      = next_idx(rear_q);
          out_valid_d = 1'b1;
          out_value_d = step_sum[WordW-1:1];
          out_last_d  = last_q;
          state_d     = StIdle;
        end
        // else hold until the output register frees up
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      front_q     <= idx_t'(RingSep);
      rear_q      <= '0;
      seeded_q    <= 1'b0;
      seed_q      <= word_t'(1);
      out_valid_q <= 1'b0;
      warm_q      <= '0;
      seed_idx_q  <= '0;
    end else begin
      state_q     <= state_d;
      front_q     <= front_d;
      rear_q      <= rear_d;
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      warm_q      <= warm_d;
      seed_idx_q  <= seed_idx_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    last_q      <= last_d;
    prev_q      <= prev_d;
  end

  // Ring register file: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_waddr] <= mem_wdata;
    end
    rd_front_q <= ring_mem[front_q];
    rd_rear_q  <= ring_mem[rear_q];
  end

  // Both indices stay inside the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_q < idx_t'(RingDeg)) && (rear_q < idx_t'(RingDeg)))
    else $error("ring index out of range");

  // The front tap leads the rear tap by the separation, modulo the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_q == rear_q + idx_t'(RingSep)) ||
    (front_q + idx_t'(RingDeg) == rear_q + idx_t'(RingSep)))
    else $error("tap separation lost");

  // A result only appears from the write-back step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == StStepWr)
    else $error("result raised outside write-back");

  // No result before the ring has been seeded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> seeded_q)
    else $error("result from unseeded ring");

endmodule

`default_nettype wire

// ----- dv/tb_additive_feedback_random_generator.sv -----
`timescale 1ns / 1ps

module tb_additive_feedback_random_generator;
  import afrg_pkg::*;

  localparam int unsigned WarmupSteps = 310;
  localparam longint      LcgModulus  = 64'sd2147483647;
  localparam int unsigned CycleLimit  = 1500000;

  typedef struct packed {
    logic restart;
    logic end_run;
    logic drain;
  } request_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              last;
  } random_word_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [31:0] cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;  // [0] restart, [7:1] zero
  logic        s_axis_tlast_i  = 1'b0;  // end_of_run
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;  // [30:0] value, [31] zero
  logic        m_axis_tlast_o;  // last_of_run

  // Mirror of the generator state
  word_t       ring_mirror [RingDeg];
  idx_t        front_ptr     = idx_t'(RingSep);
  idx_t        rear_ptr      = '0;
  logic        ring_seeded   = 1'b0;
  word_t       seed_mirror   = word_t'(1);

  request_t     request_q[$];
  random_word_t awaited_values[$];
  request_t     cur_request  = '0;
  int           tx_idle_pct  = 0;
  int           rx_idle_pct  = 0;
  int           error_count  = 0;
  int unsigned  cycle_count  = 0;

  additive_feedback_random_generator #(
    .WARMUP_STEPS(WarmupSteps)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // One additive step: front word += rear word, both pointers wrap at the ring end
  function automatic word_t ring_step();
    word_t sum;
    sum = ring_mirror[front_ptr] + ring_mirror[rear_ptr];
    ring_mirror[front_ptr] = sum;
    front_ptr = (front_ptr == idx_t'(RingDeg - 1)) ? '0 : front_ptr + idx_t'(1);
    rear_ptr  = (rear_ptr == idx_t'(RingDeg - 1)) ? '0 : rear_ptr + idx_t'(1);
    return sum;
  endfunction

  function automatic void reseed_ring();
    longint prev_word;
    longint residue;
    word_t  discard;
    int     i;
    ring_mirror[0] = (seed_mirror == '0) ? word_t'(1) : seed_mirror;
    for (i = 1; i < RingDeg; i++) begin
      // previous word taken as signed; remainder truncates toward zero
      prev_word = longint'($signed(ring_mirror[i-1]));
      residue   = (longint'(LcgMult) * prev_word) % LcgModulus;
      if (residue < 0) begin
        residue = residue + LcgModulus;
      end
      ring_mirror[i] = word_t'(residue);
    end
    front_ptr = idx_t'(RingSep);
    rear_ptr  = '0;
    for (i = 0; i < WarmupSteps; i++) begin
      discard = ring_step();
    end
    ring_seeded = 1'b1;
  endfunction

  function automatic logic [ValueW-1:0] next_random_value(input logic restart);
    word_t sum;
    if (restart || !ring_seeded) begin
      reseed_ring();
    end
    sum = ring_step();
    return sum[WordW-1:1];
  endfunction

  // Request driver; predicts each value as its transfer completes
  always @(posedge clk_i) begin
    random_word_t awaited;
    logic         launch;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        awaited.value = next_random_value(cur_request.restart);
        awaited.last  = cur_request.end_run;
        awaited_values.push_back(awaited);
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        launch = 1'b0;
        if (request_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          // hold a drain-marked request until every result is back
          launch = !request_q[0].drain || awaited_values.size() == 0;
        end
        if (launch) begin
          cur_request = request_q.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {7'd0, cur_request.restart};
          s_axis_tlast_i  <= cur_request.end_run;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    random_word_t awaited;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (awaited_values.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual tdata=%h tlast=%b",
                 $time, m_axis_tdata_o, m_axis_tlast_o);
        error_count++;
      end else begin
        awaited = awaited_values.pop_front();
        if (m_axis_tdata_o != {1'b0, awaited.value}) begin
          $display("%0t: value mismatch: expected %h, actual %h",
                   $time, {1'b0, awaited.value}, m_axis_tdata_o);
          error_count++;
        end
        if (m_axis_tlast_o != awaited.last) begin
          $display("%0t: tlast mismatch: expected %b, actual %b",
                   $time, awaited.last, m_axis_tlast_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_additive_feedback_random_generator: done, errors");
      $finish;
    end
  end

  task automatic queue_request(input logic restart, input logic end_run, input logic drain);
    request_t req;
    req.restart = restart;
    req.end_run = end_run;
    req.drain   = drain;
    request_q.push_back(req);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    while (request_q.size() != 0 || s_axis_tvalid_i || awaited_values.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_seed(input word_t val);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    seed_mirror = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic word_t pick_seed();
    word_t val;
    case ($urandom_range(0, 5))
      0:       val = '0;
      1:       val = 32'h7FFF_FFFF;
      2:       val = 32'hFFFF_FFFF;
      3:       val = 32'h0000_0001;
      default: val = $urandom();
    endcase
    return val;
  endfunction

  initial begin
    int phase;
    int chunk;
    int count;
    int run_len;
    int k;

    repeat (10) @(posedge clk_i);
    rst_ni      <= 1'b1;
    tx_idle_pct <= 28;
    rx_idle_pct <= 62;
    @(negedge clk_i);

    // reset seed; first request reseeds without restart
    queue_request(1'b0, 1'b0, 1'b0);
    queue_request(1'b0, 1'b0, 1'b0);
    queue_request(1'b0, 1'b1, 1'b0);
    queue_request(1'b1, 1'b0, 1'b0);
    queue_request(1'b0, 1'b0, 1'b0);
    queue_request(1'b1, 1'b1, 1'b1);
    // zero seed behaves as one; the write alone must not reseed
    write_seed('0);
    queue_request(1'b0, 1'b0, 1'b0);
    queue_request(1'b1, 1'b0, 1'b0);
    queue_request(1'b0, 1'b1, 1'b0);
    // seed equal to the modulus zeroes word one
    write_seed(32'h7FFF_FFFF);
    queue_request(1'b1, 1'b0, 1'b0);
    queue_request(1'b0, 1'b0, 1'b0);
    write_seed(32'hFFFF_FFFF);
    queue_request(1'b1, 1'b1, 1'b0);
    queue_request(1'b0, 1'b0, 1'b0);
    write_seed(32'h8000_0000);
    queue_request(1'b1, 1'b0, 1'b0);
    queue_request(1'b0, 1'b1, 1'b0);
    queue_request(1'b1, 1'b1, 1'b0);
    write_seed(32'h0000_0001);
    queue_request(1'b1, 1'b0, 1'b0);
    queue_request(1'b0, 1'b0, 1'b0);

    for (phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          tx_idle_pct <= 28;
          rx_idle_pct <= 62;
        end
        1: begin
          tx_idle_pct <= 62;
          rx_idle_pct <= 28;
        end
        default: begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
      endcase
      for (chunk = 0; chunk < 4; chunk++) begin
        write_seed(pick_seed());
        count = 0;
        while (count < 58) begin
          // runs closed by tlast, often opened by a restart
          run_len = $urandom_range(1, 16);
          for (k = 0; k < run_len && count < 58; k++) begin
            queue_request((k == 0 && $urandom_range(0, 3) == 0) ||
                          $urandom_range(0, 39) == 0,
                          (k == run_len - 1) || $urandom_range(0, 29) == 0,
                          $urandom_range(0, 49) == 0);
            count++;
          end
        end
      end
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_additive_feedback_random_generator: done, clean");
    end else begin
      $display("tb_additive_feedback_random_generator: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/afrg_pkg.sv
hdl/afrg_seed_mul.sv
hdl/additive_feedback_random_generator.sv
dv/tb_additive_feedback_random_generator.sv
